/* rtl/core/fic_pkg.sv */
`timescale 1ns / 1ps
package fic_pkg;

  localparam int CHANNELS       = 6;
  localparam int OPS            = 4;
  localparam int FIELDS         = 10;
  localparam int REC_LEN        = 42;
  localparam int BYTE_W         = 7;
  localparam int PACK_W         = 178;
  localparam int TAG_W          = 16;
  localparam int TABLE_DEPTH_DEF = 256;

  localparam logic [7:0] REG_DAC    = 8'h2b;
  localparam logic [7:0] REG_KEY    = 8'h28;
  localparam logic [7:0] REG_LO     = 8'h30;
  localparam logic [7:0] REG_HI     = 8'hb3;
  localparam logic [6:0] TL_QUIET   = 7'h7e;

  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_NEW     = 3'd1;
  localparam logic [2:0] ST_KNOWN   = 3'd2;
  localparam logic [2:0] ST_SILENT  = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  // field slots inside one operator
  localparam int F_MUL = 0;
  localparam int F_DT  = 1;
  localparam int F_TL  = 2;
  localparam int F_RS  = 3;
  localparam int F_AR  = 4;
  localparam int F_D1  = 5;
  localparam int F_D2  = 6;
  localparam int F_RR  = 7;
  localparam int F_SL  = 8;
  localparam int F_SSG = 9;

  typedef logic [REC_LEN-1:0][BYTE_W-1:0] rec_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_HOLD,
    S_EMIT
  } state_t;

  // stored width of each operator field
  function automatic int fld_w(input int f);
    case (f)
      F_MUL:   fld_w = 4;
      F_DT:    fld_w = 3;
      F_TL:    fld_w = 7;
      F_RS:    fld_w = 2;
      F_AR:    fld_w = 5;
      F_D1:    fld_w = 5;
      F_D2:    fld_w = 5;
      default: fld_w = 4;
    endcase
  endfunction

  // detune code to record value (offset by 3)
  function automatic logic [BYTE_W-1:0] dt_map(input logic [2:0] c);
    case (c)
      3'd0:    dt_map = 7'd3;
      3'd1:    dt_map = 7'd4;
      3'd2:    dt_map = 7'd5;
      3'd3:    dt_map = 7'd6;
      3'd4:    dt_map = 7'd3;
      3'd5:    dt_map = 7'd2;
      3'd6:    dt_map = 7'd1;
      default: dt_map = 7'd0;
    endcase
  endfunction

  // squeeze a record into its meaningful bits
  function automatic logic [PACK_W-1:0] rec_pack(input rec_t r);
    int pos;
    rec_pack = '0;
    pos = 0;
    for (int b = 0; b < 3; b++) begin
      rec_pack[pos] = r[0][b];
      pos++;
    end
    for (int b = 0; b < 3; b++) begin
      rec_pack[pos] = r[1][b];
      pos++;
    end
    for (int o = 0; o < OPS; o++) begin
      for (int f = 0; f < FIELDS; f++) begin
        for (int b = 0; b < BYTE_W; b++) begin
          if (b < fld_w(f)) begin
            rec_pack[pos] = r[2 + o * FIELDS + f][b];
            pos++;
          end
        end
      end
    end
  endfunction

endpackage

/* rtl/core/fm_instrument_capture_top.sv */
`timescale 1ns / 1ps
// channel | ports                                              | direction
// input   | in_valid in_ready in_command in_bank in_reg_address | in
//         | in_write_value in_source_id                          |
// result  | out_valid out_ready out_status out_entry_index       | out
//         | out_tagged_source out_record_byte out_last           |
//
// one item at a time: an item that gives a single result is accepted, then
// held in the result register until out_ready takes it
// a key-on with a changed, audible instrument walks the table one stored
// entry at a time (memory read then compare), then a new instrument streams its
// 42 record bytes out of the cell row, one per accepted result
// reset clears shadows, key-on history, dac flag and the entry count; the
// table memory itself is not cleared, the count guards it
// out_ready low simply holds the current result
module fm_instrument_capture_top #(
  parameter int TABLE_DEPTH = fic_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic        in_bank,
  input  logic [7:0]  in_reg_address,
  input  logic [7:0]  in_write_value,
  input  logic [15:0] in_source_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_entry_index,
  output logic [15:0] out_tagged_source,
  output logic [6:0]  out_record_byte,
  output logic        out_last
);

  localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int RW  = fic_pkg::PACK_W + fic_pkg::TAG_W;
  localparam int EW  = $clog2(fic_pkg::REC_LEN);
  localparam int BW  = fic_pkg::BYTE_W;

  // shadow state
  logic [BW-1:0] shd_r  [fic_pkg::CHANNELS][fic_pkg::OPS][fic_pkg::FIELDS];
  logic [2:0]    algo_r [fic_pkg::CHANNELS];
  logic [2:0]    fb_r   [fic_pkg::CHANNELS];
  logic [fic_pkg::PACK_W-1:0] prev_r [fic_pkg::CHANNELS];
  logic [fic_pkg::CHANNELS-1:0] prev_vld_r;
  logic          dac_r;
  logic [CW-1:0] known_cnt_r;

  // control
  fic_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [EW-1:0] emit_r, emit_nxt;
  logic [2:0]    status_r, status_nxt;
  logic [7:0]    idx_r, idx_nxt;
  logic [15:0]   tag_r, tag_nxt;
  logic [15:0]   src_r;
  logic [fic_pkg::PACK_W-1:0] pack_r;
  fic_pkg::rec_t rec_r;

  logic accept;
  assign accept = in_valid && in_ready;

  // register write decode
  logic          wr_hit;
  logic [2:0]    wr_ch;
  logic [1:0]    wr_op;
  assign wr_hit = !in_command &&
                  (in_reg_address inside {[fic_pkg::REG_LO:fic_pkg::REG_HI]}) &&
                  in_reg_address[1:0] != 2'd3;
  assign wr_ch  = {1'b0, in_reg_address[1:0]} + (in_bank ? 3'd3 : 3'd0);
  assign wr_op  = in_reg_address[3:2];

  // key event decode
  logic          is_key, is_dac, key_skip, key_on;
  logic [2:0]    kcode, kch;
  assign is_key = !in_command && !in_bank && in_reg_address == fic_pkg::REG_KEY;
  assign is_dac = !in_command && !in_bank && in_reg_address == fic_pkg::REG_DAC;
  assign kcode  = in_write_value[2:0];
  assign kch    = (kcode > 3'd3) ? kcode - 3'd1 : kcode;
  assign key_skip = (kcode inside {3'd3, 3'd7}) || (kch == 3'd5 && dac_r);
  assign key_on = is_key && !key_skip && in_write_value[7:4] != 4'd0;

  // record of the keyed channel, straight from the shadow
  fic_pkg::rec_t rec_c;
  logic [fic_pkg::PACK_W-1:0] pack_c;
  logic no_attack, all_quiet, changed;
  always_comb begin
    rec_c = '0;
    no_attack = 1'b1;
    all_quiet = 1'b1;
    rec_c[0] = BW'(algo_r[kch]);
    rec_c[1] = BW'(fb_r[kch]);
    for (int o = 0; o < fic_pkg::OPS; o++) begin
      for (int f = 0; f < fic_pkg::FIELDS; f++) begin
        rec_c[2 + o * fic_pkg::FIELDS + f] = (f == fic_pkg::F_DT) ?
          fic_pkg::dt_map(shd_r[kch][o][f][2:0]) : shd_r[kch][o][f];
      end
      if (shd_r[kch][o][fic_pkg::F_AR] != '0) no_attack = 1'b0;
      if (shd_r[kch][o][fic_pkg::F_TL] <= fic_pkg::TL_QUIET) all_quiet = 1'b0;
    end
  end
  assign pack_c  = fic_pkg::rec_pack(rec_c);
  assign changed = !prev_vld_r[kch] || prev_r[kch] != pack_c;

  // table memory: packed record plus source tag
  logic          ram_we;
  logic [RW-1:0] ram_q;
  logic          hit;
  logic          full;
  assign hit  = ram_q[fic_pkg::PACK_W-1:0] == pack_r;
  assign full = known_cnt_r >= CW'(TABLE_DEPTH);

  fic_ram #(.WIDTH(RW), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (known_cnt_r[AW-1:0]),
    .wdata ({src_r, pack_r}),
    .raddr (cnt_r[AW-1:0]),
    .rdata (ram_q)
  );

  // record cells: load on a new entry, shift one byte per taken result
  logic          cell_load, cell_shift;
  logic [BW-1:0] cell_q [fic_pkg::REC_LEN];

  for (genvar k = 0; k < fic_pkg::REC_LEN; k++) begin : g_cell
    logic [BW-1:0] sin;
    if (k == fic_pkg::REC_LEN - 1) begin : g_end
      assign sin = '0;
    end else begin : g_mid
      assign sin = cell_q[k + 1];
    end
    fic_cell u_cell (
      .clk      (clk),
      .load     (cell_load),
      .shift    (cell_shift),
      .load_val (rec_r[k]),
      .shift_in (sin),
      .q        (cell_q[k])
    );
  end

  // state machine
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    emit_nxt   = emit_r;
    status_nxt = status_r;
    idx_nxt    = idx_r;
    tag_nxt    = tag_r;
    ram_we     = 1'b0;
    cell_load  = 1'b0;
    cell_shift = 1'b0;
    in_ready   = 1'b0;
    case (state_r)
      fic_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          status_nxt = fic_pkg::ST_NONE;
          idx_nxt    = '0;
          tag_nxt    = '0;
          state_nxt  = fic_pkg::S_HOLD;
          if (key_on && changed) begin
            if (no_attack || all_quiet) begin
              status_nxt = fic_pkg::ST_SILENT;
            end else begin
              cnt_nxt   = '0;
              state_nxt = fic_pkg::S_RD;
            end
          end
        end
      end
      fic_pkg::S_RD: begin
        if (cnt_r == known_cnt_r) begin
          if (full) begin
            status_nxt = fic_pkg::ST_FULL;
            state_nxt  = fic_pkg::S_HOLD;
          end else begin
            ram_we     = 1'b1;
            cell_load  = 1'b1;
            status_nxt = fic_pkg::ST_NEW;
            idx_nxt    = 8'(known_cnt_r);
            tag_nxt    = src_r;
            emit_nxt   = '0;
            state_nxt  = fic_pkg::S_EMIT;
          end
        end else begin
          state_nxt = fic_pkg::S_CMP;
        end
      end
      fic_pkg::S_CMP: begin
        if (hit) begin
          status_nxt = fic_pkg::ST_KNOWN;
          idx_nxt    = 8'(cnt_r);
          tag_nxt    = ram_q[RW-1:fic_pkg::PACK_W];
          state_nxt  = fic_pkg::S_HOLD;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = fic_pkg::S_RD;
        end
      end
      fic_pkg::S_HOLD: begin
        if (out_ready) state_nxt = fic_pkg::S_IDLE;
      end
      fic_pkg::S_EMIT: begin
        if (out_ready) begin
          cell_shift = 1'b1;
          if (emit_r == EW'(fic_pkg::REC_LEN - 1)) begin
            state_nxt = fic_pkg::S_IDLE;
          end else begin
            emit_nxt = emit_r + 1'b1;
          end
        end
      end
      default: state_nxt = fic_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fic_pkg::S_IDLE;
      known_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (ram_we) known_cnt_r <= known_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    emit_r   <= emit_nxt;
    status_r <= status_nxt;
    idx_r    <= idx_nxt;
    tag_r    <= tag_nxt;
    if (accept) begin
      src_r  <= in_source_id;
      pack_r <= pack_c;
      rec_r  <= rec_c;
    end
  end

  // key-on history; the packed copy itself needs no reset
  always_ff @(posedge clk) begin
    if (accept && key_on) prev_r[kch] <= pack_c;
  end

  // shadows, dac flag, key-on valid bits
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_command)) begin
      for (int c = 0; c < fic_pkg::CHANNELS; c++) begin
        algo_r[c] <= '0;
        fb_r[c]   <= '0;
        for (int o = 0; o < fic_pkg::OPS; o++) begin
          for (int f = 0; f < fic_pkg::FIELDS; f++) begin
            shd_r[c][o][f] <= '0;
          end
        end
      end
      prev_vld_r <= '0;
      dac_r      <= 1'b0;
    end else if (accept) begin
      if (is_dac) dac_r <= in_write_value[7];
      if (key_on) prev_vld_r[kch] <= 1'b1;
      if (wr_hit) begin
        case (in_reg_address[7:4])
          4'h3: begin
            shd_r[wr_ch][wr_op][fic_pkg::F_DT]  <= BW'(in_write_value[6:4]);
            shd_r[wr_ch][wr_op][fic_pkg::F_MUL] <= BW'(in_write_value[3:0]);
          end
          4'h4: shd_r[wr_ch][wr_op][fic_pkg::F_TL] <= in_write_value[6:0];
          4'h5: begin
            shd_r[wr_ch][wr_op][fic_pkg::F_RS] <= BW'(in_write_value[7:6]);
            shd_r[wr_ch][wr_op][fic_pkg::F_AR] <= BW'(in_write_value[4:0]);
          end
          4'h6: shd_r[wr_ch][wr_op][fic_pkg::F_D1] <= BW'(in_write_value[4:0]);
          4'h7: shd_r[wr_ch][wr_op][fic_pkg::F_D2] <= BW'(in_write_value[4:0]);
          4'h8: begin
            shd_r[wr_ch][wr_op][fic_pkg::F_SL] <= BW'(in_write_value[7:4]);
            shd_r[wr_ch][wr_op][fic_pkg::F_RR] <= BW'(in_write_value[3:0]);
          end
          4'h9: shd_r[wr_ch][wr_op][fic_pkg::F_SSG] <= BW'(in_write_value[3:0]);
          4'hb: begin
            algo_r[wr_ch] <= in_write_value[2:0];
            fb_r[wr_ch]   <= in_write_value[5:3];
          end
          default: ;
        endcase
      end
    end
  end

  // result port
  assign out_valid         = state_r == fic_pkg::S_HOLD || state_r == fic_pkg::S_EMIT;
  assign out_status        = status_r;
  assign out_entry_index   = idx_r;
  assign out_tagged_source = tag_r;
  assign out_record_byte   = (state_r == fic_pkg::S_EMIT) ? cell_q[0] : '0;
  assign out_last          = state_r == fic_pkg::S_HOLD ||
                             emit_r == EW'(fic_pkg::REC_LEN - 1);

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while a result waits");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    known_cnt_r <= CW'(TABLE_DEPTH)) else $error("entry count past table depth");

  a_store_emits: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (state_r == fic_pkg::S_EMIT && emit_r == '0))
    else $error("stored entry not followed by record");

  a_emit_status: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fic_pkg::S_EMIT |-> out_status == fic_pkg::ST_NEW)
    else $error("record byte with wrong status");

endmodule

/* rtl/core/fic_ram.sv */
`timescale 1ns / 1ps
module fic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/fic_cell.sv */
`timescale 1ns / 1ps
module fic_cell (
  input  logic                      clk,
  input  logic                      load,
  input  logic                      shift,
  input  logic [fic_pkg::BYTE_W-1:0] load_val,
  input  logic [fic_pkg::BYTE_W-1:0] shift_in,
  output logic [fic_pkg::BYTE_W-1:0] q
);

  logic [fic_pkg::BYTE_W-1:0] q_r;

  // one record byte; shifts toward the output end
  always_ff @(posedge clk) begin
    if (load) begin
      q_r <= load_val;
    end else if (shift) begin
      q_r <= shift_in;
    end
  end

  assign q = q_r;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
module testbench;

  localparam int DEPTH = fic_pkg::TABLE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic        command;
    logic        bank;
    logic [7:0]  reg_address;
    logic [7:0]  write_value;
    logic [15:0] source_id;
  } write_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  entry_index;
    logic [15:0] tagged_source;
    logic [6:0]  record_byte;
    logic        last;
  } capture_result_t;

  typedef logic [6:0] record_t [fic_pkg::REC_LEN];

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_command;
  logic        in_bank;
  logic [7:0]  in_reg_address;
  logic [7:0]  in_write_value;
  logic [15:0] in_source_id;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [7:0]  out_entry_index;
  logic [15:0] out_tagged_source;
  logic [6:0]  out_record_byte;
  logic        out_last;

  fm_instrument_capture_top DUT (.*);

  // clock, 10 ns period
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // writes waiting to be offered, and results the shadow model predicts
  write_item_t     pending_writes[$];
  capture_result_t expected_results[$];

  int  sender_idle_pct;
  int  receiver_idle_pct;
  bit  hold_request;
  int  hold_left;
  int  error_count;
  int  cycle_count;

  // shadow of the synthesizer registers as the block should see them
  logic [6:0]  op_shadow [fic_pkg::CHANNELS][fic_pkg::OPS][fic_pkg::FIELDS];
  logic [6:0]  algo_shadow [fic_pkg::CHANNELS];
  logic [6:0]  feedback_shadow [fic_pkg::CHANNELS];
  record_t     last_keyon_record [fic_pkg::CHANNELS];
  bit          last_keyon_valid [fic_pkg::CHANNELS];
  bit          dac_on;
  record_t     instrument_table [DEPTH];
  logic [15:0] instrument_tag [DEPTH];
  int          instrument_count;

  // detune code 0..7 to its signed offset plus 3
  localparam logic [6:0] DETUNE_OFFSET [8] = '{7'd3, 7'd4, 7'd5, 7'd6, 7'd3, 7'd2, 7'd1, 7'd0};

  function automatic capture_result_t single_result(logic [2:0] st, logic [7:0] idx,
                                                    logic [15:0] tag);
    capture_result_t r;
    r.status = st;
    r.entry_index = idx;
    r.tagged_source = tag;
    r.record_byte = '0;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic record_t assemble_record(int ch);
    record_t rec;
    rec[0] = algo_shadow[ch];
    rec[1] = feedback_shadow[ch];
    for (int o = 0; o < fic_pkg::OPS; o++)
      for (int f = 0; f < fic_pkg::FIELDS; f++)
        rec[2 + o * fic_pkg::FIELDS + f] = (f == fic_pkg::F_DT) ?
                                           DETUNE_OFFSET[op_shadow[ch][o][f][2:0]] :
                                           op_shadow[ch][o][f];
    return rec;
  endfunction

  function automatic bit records_equal(record_t a, record_t b);
    for (int i = 0; i < fic_pkg::REC_LEN; i++)
      if (a[i] !== b[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit is_silent(record_t rec);
    bit no_attack;
    bit all_quiet;
    no_attack = 1'b1;
    all_quiet = 1'b1;
    for (int o = 0; o < fic_pkg::OPS; o++) begin
      if (rec[2 + o * fic_pkg::FIELDS + fic_pkg::F_AR] != 0) no_attack = 1'b0;
      if (rec[2 + o * fic_pkg::FIELDS + fic_pkg::F_TL] <= fic_pkg::TL_QUIET) all_quiet = 1'b0;
    end
    return no_attack || all_quiet;
  endfunction

  // key register write: compare with the previous key-on, then search the table
  task automatic predict_key_event(logic [7:0] val, logic [15:0] src);
    int      code;
    int      ch;
    int      hit;
    record_t rec;
    capture_result_t r;
    code = val[2:0];
    if (code == 3 || code == 7) begin
      expected_results.push_back(single_result(fic_pkg::ST_NONE, '0, '0));
      return;
    end
    ch = (code > 3) ? code - 1 : code;
    if ((ch == 5 && dac_on) || val[7:4] == 0) begin
      expected_results.push_back(single_result(fic_pkg::ST_NONE, '0, '0));
      return;
    end
    rec = assemble_record(ch);
    if (last_keyon_valid[ch] && records_equal(last_keyon_record[ch], rec)) begin
      expected_results.push_back(single_result(fic_pkg::ST_NONE, '0, '0));
    end else if (is_silent(rec)) begin
      expected_results.push_back(single_result(fic_pkg::ST_SILENT, '0, '0));
    end else begin
      hit = -1;
      for (int i = 0; i < instrument_count; i++)
        if (hit < 0 && records_equal(instrument_table[i], rec)) hit = i;
      if (hit >= 0) begin
        expected_results.push_back(single_result(fic_pkg::ST_KNOWN, hit[7:0],
                                                 instrument_tag[hit]));
      end else if (instrument_count >= DEPTH) begin
        expected_results.push_back(single_result(fic_pkg::ST_FULL, '0, '0));
      end else begin
        instrument_table[instrument_count] = rec;
        instrument_tag[instrument_count] = src;
        for (int i = 0; i < fic_pkg::REC_LEN; i++) begin
          r.status = fic_pkg::ST_NEW;
          r.entry_index = instrument_count[7:0];
          r.tagged_source = src;
          r.record_byte = rec[i];
          r.last = (i == fic_pkg::REC_LEN - 1);
          expected_results.push_back(r);
        end
        instrument_count++;
      end
    end
    last_keyon_record[ch] = rec;
    last_keyon_valid[ch] = 1'b1;
  endtask

  task automatic predict_write(write_item_t it);
    int ch;
    int op;
    logic [7:0] v;
    v = it.write_value;
    if (it.command) begin
      // new source: shadows and dac cleared, table kept
      for (int c = 0; c < fic_pkg::CHANNELS; c++) begin
        for (int o = 0; o < fic_pkg::OPS; o++)
          for (int f = 0; f < fic_pkg::FIELDS; f++) op_shadow[c][o][f] = '0;
        algo_shadow[c] = '0;
        feedback_shadow[c] = '0;
        last_keyon_valid[c] = 1'b0;
      end
      dac_on = 1'b0;
      expected_results.push_back(single_result(fic_pkg::ST_NONE, '0, '0));
      return;
    end
    if (!it.bank && it.reg_address == fic_pkg::REG_DAC) begin
      dac_on = v[7];
      expected_results.push_back(single_result(fic_pkg::ST_NONE, '0, '0));
      return;
    end
    if (!it.bank && it.reg_address == fic_pkg::REG_KEY) begin
      predict_key_event(v, it.source_id);
      return;
    end
    if (it.reg_address >= fic_pkg::REG_LO && it.reg_address <= fic_pkg::REG_HI &&
        it.reg_address[1:0] != 2'd3) begin
      ch = it.reg_address[1:0] + (it.bank ? 3 : 0);
      op = it.reg_address[3:2];
      case (it.reg_address[7:4])
        4'h3: begin
          op_shadow[ch][op][fic_pkg::F_DT] = {4'd0, v[6:4]};
          op_shadow[ch][op][fic_pkg::F_MUL] = {3'd0, v[3:0]};
        end
        4'h4: op_shadow[ch][op][fic_pkg::F_TL] = v[6:0];
        4'h5: begin
          op_shadow[ch][op][fic_pkg::F_RS] = {5'd0, v[7:6]};
          op_shadow[ch][op][fic_pkg::F_AR] = {2'd0, v[4:0]};
        end
        4'h6: op_shadow[ch][op][fic_pkg::F_D1] = {2'd0, v[4:0]};
        4'h7: op_shadow[ch][op][fic_pkg::F_D2] = {2'd0, v[4:0]};
        4'h8: begin
          op_shadow[ch][op][fic_pkg::F_SL] = {3'd0, v[7:4]};
          op_shadow[ch][op][fic_pkg::F_RR] = {3'd0, v[3:0]};
        end
        4'h9: op_shadow[ch][op][fic_pkg::F_SSG] = {3'd0, v[3:0]};
        4'hb: begin
          algo_shadow[ch] = {4'd0, v[2:0]};
          feedback_shadow[ch] = {4'd0, v[5:3]};
        end
        default: ;
      endcase
    end
    expected_results.push_back(single_result(fic_pkg::ST_NONE, '0, '0));
  endtask

  // sender: predict on acceptance, then offer the next item or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_command <= 1'b0;
      in_bank <= 1'b0;
      in_reg_address <= '0;
      in_write_value <= '0;
      in_source_id <= '0;
    end else begin
      if (in_valid && in_ready)
        predict_write({in_command, in_bank, in_reg_address, in_write_value, in_source_id});
      if (!in_valid || in_ready) begin
        if (pending_writes.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          write_item_t it;
          it = pending_writes.pop_front();
          in_valid <= 1'b1;
          in_command <= it.command;
          in_bank <= it.bank;
          in_reg_address <= it.reg_address;
          in_write_value <= it.write_value;
          in_source_id <= it.source_id;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each accepted result against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: status %0d", out_status);
          error_count++;
        end else begin
          capture_result_t e;
          e = expected_results.pop_front();
          if (out_status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_status);
            error_count++;
          end
          if (out_entry_index !== e.entry_index) begin
            $error("entry_index expected %0d actual %0d", e.entry_index, out_entry_index);
            error_count++;
          end
          if (out_tagged_source !== e.tagged_source) begin
            $error("tagged_source expected %0h actual %0h", e.tagged_source, out_tagged_source);
            error_count++;
          end
          if (out_record_byte !== e.record_byte) begin
            $error("record_byte expected %0h actual %0h", e.record_byte, out_record_byte);
            error_count++;
          end
          if (out_last !== e.last) begin
            $error("last expected %0d actual %0d", e.last, out_last);
            error_count++;
          end
        end
      end
      // a long hold-off lets the block back up and stall its input
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 500;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic add_write(logic cmd, logic bnk, logic [7:0] addr, logic [7:0] val);
    write_item_t it;
    it.command = cmd;
    it.bank = bnk;
    it.reg_address = addr;
    it.write_value = val;
    it.source_id = 16'($urandom_range(16'hffff));
    pending_writes.push_back(it);
  endtask

  // wait until every offered item is taken and every result has come back
  task automatic drain();
    while (pending_writes.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  // a mostly well-formed write: parameter registers with values from a small
  // pool so instruments repeat, key events, some dac, new source and noise
  task automatic add_random_write();
    int kind;
    logic [7:0] addr;
    logic [7:0] val;
    kind = $urandom_range(99);
    val = ($urandom_range(2) == 0) ? 8'($urandom_range(255))
                                   : 8'(8'h11 * $urandom_range(0, 3));
    if (kind < 6) begin
      add_write(1'b1, 1'($urandom_range(1)), 8'($urandom_range(255)),
                8'($urandom_range(255)));
    end else if (kind < 12) begin
      add_write(1'b0, 1'($urandom_range(1)), 8'($urandom_range(255)),
                8'($urandom_range(255)));
    end else if (kind < 18) begin
      add_write(1'b0, 1'b0, fic_pkg::REG_DAC, 8'($urandom_range(255)));
    end else if (kind < 48) begin
      val = {($urandom_range(7) == 0) ? 4'h0 : 4'($urandom_range(1, 15)),
             1'($urandom_range(1)), 3'($urandom_range(7))};
      add_write(1'b0, 1'b0, fic_pkg::REG_KEY, val);
    end else begin
      addr = {4'($urandom_range(3, 11)), 2'($urandom_range(3)), 2'($urandom_range(2))};
      if (addr[7:4] == 4'ha) addr[7:4] = 4'hb;
      // keep attack mostly audible so the table fills with real instruments
      if (addr[7:4] == 4'h5 && $urandom_range(3) != 0) val[4:0] = 5'($urandom_range(1, 31));
      add_write(1'b0, 1'($urandom_range(1)), addr, val);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    error_count = 0;
    cycle_count = 0;
    hold_request = 1'b0;
    sender_idle_pct = 22;
    receiver_idle_pct = 84;
    instrument_count = 0;
    dac_on = 1'b0;
    for (int c = 0; c < fic_pkg::CHANNELS; c++) begin
      for (int o = 0; o < fic_pkg::OPS; o++)
        for (int f = 0; f < fic_pkg::FIELDS; f++) op_shadow[c][o][f] = '0;
      algo_shadow[c] = '0;
      feedback_shadow[c] = '0;
      last_keyon_valid[c] = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: full-scale instrument on channel 0, every register group
    add_write(1'b0, 1'b0, 8'h30, 8'hff);
    add_write(1'b0, 1'b0, 8'h44, 8'hff);
    add_write(1'b0, 1'b0, 8'h58, 8'hff);
    add_write(1'b0, 1'b0, 8'h6c, 8'hff);
    add_write(1'b0, 1'b0, 8'h70, 8'hff);
    add_write(1'b0, 1'b0, 8'h84, 8'hff);
    add_write(1'b0, 1'b0, 8'h98, 8'hff);
    add_write(1'b0, 1'b0, 8'hb0, 8'hff);
    add_write(1'b0, 1'b0, fic_pkg::REG_KEY, 8'hf0);     // new instrument
    add_write(1'b0, 1'b0, fic_pkg::REG_KEY, 8'h00);     // key-off
    add_write(1'b0, 1'b0, fic_pkg::REG_KEY, 8'h10);     // unchanged instrument
    add_write(1'b0, 1'b0, 8'h33, 8'h55);                // low bits three, ignored
    add_write(1'b0, 1'b1, fic_pkg::REG_KEY, 8'hf0);     // bank 1 key register, ignored
    add_write(1'b0, 1'b0, fic_pkg::REG_KEY, 8'hf3);     // invalid channel code
    add_write(1'b0, 1'b0, fic_pkg::REG_KEY, 8'hf7);     // invalid channel code
    add_write(1'b0, 1'b0, fic_pkg::REG_KEY, 8'hf1);     // silent, no attack
    add_write(1'b0, 1'b0, 8'h52, 8'h1f);
    add_write(1'b0, 1'b0, 8'h42, 8'h7f);
    add_write(1'b0, 1'b0, fic_pkg::REG_KEY, 8'hf2);     // new instrument, not all levels quiet
    add_write(1'b0, 1'b1, 8'h52, 8'h01);
    add_write(1'b0, 1'b0, fic_pkg::REG_DAC, 8'h80);
    add_write(1'b0, 1'b0, fic_pkg::REG_KEY, 8'hf6);     // dac channel, ignored
    add_write(1'b0, 1'b0, fic_pkg::REG_KEY, 8'hf5);     // channel 4 via bank 1
    add_write(1'b1, 1'b0, 8'h00, 8'h00);                // new source
    add_write(1'b0, 1'b0, fic_pkg::REG_KEY, 8'hf6);     // dac now off, silent channel

    for (int i = 0; i < 80; i++) add_random_write();
    drain();

    // second phase: sender mostly idle, receiver mostly ready
    sender_idle_pct = 84;
    receiver_idle_pct = 22;
    for (int i = 0; i < 80; i++) add_random_write();
    drain();

    // third phase: no idling; long receiver hold-off over a run of new instruments
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    hold_request = 1'b1;
    add_write(1'b1, 1'b0, 8'h00, 8'h00);
    for (int o = 0; o < fic_pkg::OPS; o++) add_write(1'b0, 1'b0, 8'h50 + 8'(o * 4), 8'h1f);
    for (int i = 0; i < 10; i++) begin
      add_write(1'b0, 1'b0, 8'h40, 8'(i & 8'h7f));
      add_write(1'b0, 1'b0, 8'h30, 8'((i >> 7) & 8'h0f));
      add_write(1'b0, 1'b0, fic_pkg::REG_KEY, 8'hf0);
    end
    // a known one again
    add_write(1'b0, 1'b0, 8'h40, 8'h00);
    add_write(1'b0, 1'b0, 8'h30, 8'h00);
    add_write(1'b0, 1'b0, fic_pkg::REG_KEY, 8'hf0);
    drain();
    repeat (50) @(posedge clk);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
